// ===== sv/vf_pkg.sv =====
package vf_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int NumVars   = 5;

  // register file map: stores first, then scratch, then the registers and the constant
  localparam int R_RHO = 0;
  localparam int R_MOM = 1;
  localparam int R_EN  = 4;
  localparam int R_GRD = 5;   // 5 + 3*var + dir
  localparam int R_REC = 20;
  localparam int R_U   = 21;
  localparam int R_L   = 24;  // 24 + 3*a + b
  localparam int R_DIV = 33;
  localparam int R_LAM = 34;
  localparam int R_T   = 35;
  localparam int R_TAU = 36;  // 36 + 3*a + b
  localparam int R_EPS = 45;
  localparam int R_K   = 46;
  localparam int R_G   = 47;
  localparam int R_GE  = 48;
  localparam int R_IRE = 54;
  localparam int R_GOP = 55;
  localparam int R_TT  = 56;

  // stores hold addresses below NumStore, scratch starts at ScrBase
  localparam int NumStore   = 20;
  localparam int ScrBase    = R_REC;
  localparam int NumScratch = R_GE + 3 - R_REC;

  localparam int NumSteps = 104;

  localparam logic [DataWidth-1:0] TwoThirds =
    DataWidth'(((2 << FracBits) + 1) / 3);

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] dst;
  } step_t;

  typedef step_t [NumSteps-1:0] prog_t;

  typedef struct packed {
    logic                 wr;
    logic [2:0]           var_index;
    logic [DataWidth-1:0] value;
    logic [DataWidth-1:0] grad_x;
    logic [DataWidth-1:0] grad_y;
    logic [DataWidth-1:0] grad_z;
    logic                 is_final;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHK,
    B_DIV,
    B_EXEC,
    B_EMIT
  } bstate_t;

  function automatic step_t mk(op_t o, int a, int b, int d);
    step_t s;
    s.op  = o;
    s.a   = 6'(a);
    s.b   = 6'(b);
    s.dst = 6'(d);
    return s;
  endfunction

  // microprogram of the flux computation
  function automatic prog_t build_prog();
    prog_t p;
    int n;
    n = 0;
    p = '0;
    for (int a = 0; a < 3; a++) begin
      p[n] = mk(OP_MUL, R_MOM + a, R_REC, R_U + a); n++;
    end
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        p[n] = mk(OP_MUL, R_U + a, R_GRD + b, R_T); n++;
        p[n] = mk(OP_SUB, R_GRD + 3 * (a + 1) + b, R_T, R_T); n++;
        p[n] = mk(OP_MUL, R_T, R_REC, R_L + 3 * a + b); n++;
      end
    end
    p[n] = mk(OP_ADD, R_L, R_L + 4, R_DIV); n++;
    p[n] = mk(OP_ADD, R_DIV, R_L + 8, R_DIV); n++;
    p[n] = mk(OP_MUL, R_TT, R_DIV, R_LAM); n++;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        p[n] = mk(OP_ADD, R_L + 3 * a + b, R_L + 3 * b + a, R_T); n++;
        if (a == b) begin
          p[n] = mk(OP_SUB, R_T, R_LAM, R_T); n++;
        end
        p[n] = mk(OP_MUL, R_T, R_IRE, R_TAU + 3 * a + b); n++;
      end
    end
    p[n] = mk(OP_MUL, R_EN, R_REC, R_EPS); n++;
    p[n] = mk(OP_MUL, R_IRE, R_GOP, R_K); n++;
    for (int b = 0; b < 3; b++) begin
      p[n] = mk(OP_MUL, R_EPS, R_GRD + b, R_T); n++;
      p[n] = mk(OP_SUB, R_GRD + 12 + b, R_T, R_T); n++;
      p[n] = mk(OP_MUL, R_T, R_REC, R_G); n++;
      for (int a = 0; a < 3; a++) begin
        p[n] = mk(OP_MUL, R_L + 3 * a + b, R_U + a, R_T); n++;
        p[n] = mk(OP_SUB, R_G, R_T, R_G); n++;
      end
      p[n] = mk(OP_MUL, R_G, R_K, R_GE + b); n++;
    end
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        p[n] = mk(OP_MUL, R_TAU + 3 * a + b, R_U + b, R_T); n++;
        p[n] = mk(OP_ADD, R_GE + a, R_T, R_GE + a); n++;
      end
    end
    return p;
  endfunction

  localparam prog_t Prog = build_prog();

endpackage

// ===== sv/vf_front.sv =====
module vf_front
  import vf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [2:0]  var_index,
  input  logic [31:0] value,
  input  logic [31:0] grad_x,
  input  logic [31:0] grad_y,
  input  logic [31:0] grad_z,
  input  logic        is_final,
  input  logic        pop,
  output logic        full,
  output logic        empty,
  output item_t       head
);

  item_t      queue [0:1];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  item_t      incoming;

  // classify: out-of-range index stores nothing
  always_comb begin
    incoming.wr        = (var_index < 3'(NumVars));
    incoming.var_index = var_index;
    incoming.value     = value;
    incoming.grad_x    = grad_x;
    incoming.grad_y    = grad_y;
    incoming.grad_z    = grad_z;
    incoming.is_final  = is_final;
  end

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = queue[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/vf_back.sv =====
module vf_back
  import vf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        empty,
  input  item_t       head,
  output logic        pop,
  output logic        done,
  output logic [2:0]  component,
  output logic [31:0] flux_x,
  output logic [31:0] flux_y,
  output logic [31:0] flux_z,
  output logic        bad_density,
  output logic        saturated,
  output logic        row_last
);

  localparam logic signed [31:0] MaxV = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MinV = 32'sh80000000;

  logic [30:0]        inv_reynolds;
  logic [30:0]        gamma_over_prandtl;
  logic signed [31:0] store   [0:NumStore-1];
  logic signed [31:0] scratch [0:NumScratch-1];
  bstate_t            state;
  bstate_t            state_next;
  logic [6:0]         step;
  logic               phase;
  logic [5:0]         dcnt;
  logic [32:0]        rem;
  logic [32:0]        quo;
  logic [2:0]         row;
  logic               bad;
  logic               sat;
  logic [63:0]        prod;
  logic               negr;

  step_t              cur;
  logic signed [31:0] rho;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic [31:0]        ua;
  logic [31:0]        ub;
  logic [64:0]        rnd;
  logic [48:0]        mag;
  logic [48:0]        limit;
  logic signed [31:0] mul_res;
  logic               mul_sat;
  logic signed [32:0] sum;
  logic signed [31:0] add_res;
  logic               add_sat;
  logic [32:0]        rem_sh;
  logic [32:0]        rem_sub;
  logic               rem_ge;
  logic               exec_last;
  logic [4:0]         dst_ix;
  logic [4:0]         val_ix;
  logic [4:0]         grd_ix;
  logic [4:0]         row_ix;

  assign cur    = Prog[step];
  assign rho    = store[5'(R_RHO)];
  assign dst_ix = 5'(cur.dst - 6'(ScrBase));
  assign val_ix = 5'(head.var_index);
  assign grd_ix = 5'(R_GRD) + 5'(head.var_index) * 5'd3;

  // operand fetch: stores, scratch, register values and the constant
  always_comb begin
    if (cur.a < 6'(NumStore)) opa = store[5'(cur.a)];
    else if (cur.a == 6'(R_IRE)) opa = $signed({1'b0, inv_reynolds});
    else if (cur.a == 6'(R_GOP)) opa = $signed({1'b0, gamma_over_prandtl});
    else if (cur.a == 6'(R_TT)) opa = $signed(TwoThirds);
    else opa = scratch[5'(cur.a - 6'(ScrBase))];
  end

  always_comb begin
    if (cur.b < 6'(NumStore)) opb = store[5'(cur.b)];
    else if (cur.b == 6'(R_IRE)) opb = $signed({1'b0, inv_reynolds});
    else if (cur.b == 6'(R_GOP)) opb = $signed({1'b0, gamma_over_prandtl});
    else if (cur.b == 6'(R_TT)) opb = $signed(TwoThirds);
    else opb = scratch[5'(cur.b - 6'(ScrBase))];
  end

  assign ua  = opa[31] ? 32'(-opa) : 32'(opa);
  assign ub  = opb[31] ? 32'(-opb) : 32'(opb);

  // round half away from zero, then saturate
  always_comb begin
    rnd   = {1'b0, prod} + 65'(1 << (FracBits - 1));
    mag   = rnd[64:FracBits];
    limit = negr ? 49'h80000000 : 49'h7FFFFFFF;
    mul_sat = (mag > limit);
    if (mul_sat) mul_res = negr ? MinV : MaxV;
    else if (negr) mul_res = -$signed(mag[31:0]);
    else mul_res = $signed(mag[31:0]);
  end

  always_comb begin
    if (cur.op == OP_SUB) sum = {opa[31], opa} - {opb[31], opb};
    else sum = {opa[31], opa} + {opb[31], opb};
    add_sat = (sum[32] != sum[31]);
    if (add_sat) add_res = sum[32] ? MinV : MaxV;
    else add_res = sum[31:0];
  end

  // restoring division of 2^32 by density, one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem[31:0], (dcnt == 6'd32)};
    rem_ge  = (rem_sh >= {2'b00, rho[30:0]});
    rem_sub = rem_sh - {2'b00, rho[30:0]};
  end

  assign exec_last = (step == 7'(NumSteps - 1)) && (cur.op != OP_MUL || phase);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!empty && head.is_final) state_next = B_CHK;
      B_CHK:  state_next = (rho <= 0) ? B_EMIT : B_DIV;
      B_DIV:  if (dcnt == 6'd0) state_next = B_EXEC;
      B_EXEC: if (exec_last) state_next = B_EMIT;
      B_EMIT: if (row == 3'd4) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_reynolds       <= 31'd6554;
      gamma_over_prandtl <= 31'd127431;
    end else if (cfg_we) begin
      if (cfg_index) gamma_over_prandtl <= cfg_data;
      else inv_reynolds <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!empty && head.wr) begin
          store[val_ix]         <= head.value;
          store[grd_ix]         <= head.grad_x;
          store[grd_ix + 5'd1]  <= head.grad_y;
          store[grd_ix + 5'd2]  <= head.grad_z;
        end
        step  <= '0;
        phase <= 1'b0;
        row   <= '0;
      end
      B_CHK: begin
        sat  <= 1'b0;
        bad  <= (rho <= 0);
        rem  <= '0;
        quo  <= '0;
        dcnt <= 6'd32;
      end
      B_DIV: begin
        rem  <= rem_ge ? rem_sub : rem_sh;
        quo  <= {quo[31:0], rem_ge};
        dcnt <= dcnt - 6'd1;
        if (dcnt == 6'd0) begin
          if ({quo[31:0], rem_ge} > 33'h7FFFFFFF) begin
            scratch[5'(R_REC - ScrBase)] <= MaxV;
            sat <= 1'b1;
          end else begin
            scratch[5'(R_REC - ScrBase)] <= $signed({quo[30:0], rem_ge});
          end
        end
      end
      B_EXEC: begin
        if (cur.op == OP_MUL) begin
          if (!phase) begin
            prod  <= ua * ub;
            negr  <= opa[31] ^ opb[31];
            phase <= 1'b1;
          end else begin
            scratch[dst_ix] <= mul_res;
            if (mul_sat) sat <= 1'b1;
            phase <= 1'b0;
            step  <= step + 7'd1;
          end
        end else begin
          scratch[dst_ix] <= add_res;
          if (add_sat) sat <= 1'b1;
          step <= step + 7'd1;
        end
      end
      B_EMIT: row <= row + 3'd1;
      default: ;
    endcase
  end

  always_comb begin
    pop         = (state == B_IDLE) && !empty;
    done        = (state == B_EMIT);
    component   = row;
    bad_density = bad;
    saturated   = sat && !bad;
    row_last    = (row == 3'd4);
    flux_x      = '0;
    flux_y      = '0;
    flux_z      = '0;
    row_ix      = 5'(R_GE - ScrBase);
    if (!bad) begin
      case (row)
        3'd1, 3'd2, 3'd3: begin
          row_ix = 5'(R_TAU - ScrBase) + 5'(row - 3'd1) * 5'd3;
          flux_x = scratch[row_ix];
          flux_y = scratch[row_ix + 5'd1];
          flux_z = scratch[row_ix + 5'd2];
        end
        3'd4: begin
          flux_x = scratch[row_ix];
          flux_y = scratch[row_ix + 5'd1];
          flux_z = scratch[row_ix + 5'd2];
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/compressible_viscous_flux_top.sv =====
// channel   ports                                             transfer when
// input     start busy var_index value grad_x/y/z is_final    start && !busy
// result    done component flux_x/y/z bad_density saturated   done (one cycle)
//           row_last
// config    cfg_we cfg_index cfg_data                         cfg_we
//
// a non-final item is stored in the cycle after its transfer when the engine is
// idle; a final item costs a density check and, for a positive density, a
// reciprocal division and a run on the shared multiply/add unit (60 multiplies
// and 44 adds).
// five result rows follow on consecutive cycles; receiver cannot stall
// a two-entry queue takes items while the engine works; busy when full
// rst is synchronous and clears queue, engine state and registers
module compressible_viscous_flux_top
  import vf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  var_index,
  input  logic [31:0] value,
  input  logic [31:0] grad_x,
  input  logic [31:0] grad_y,
  input  logic [31:0] grad_z,
  input  logic        is_final,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  output logic        done,
  output logic [2:0]  component,
  output logic [31:0] flux_x,
  output logic [31:0] flux_y,
  output logic [31:0] flux_z,
  output logic        bad_density,
  output logic        saturated,
  output logic        row_last
);

  logic  full;
  logic  empty;
  logic  pop;
  item_t head;

  assign busy = full;

  // front: input transfers land in the queue
  vf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (start && !full),
    .var_index (var_index),
    .value     (value),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .grad_z    (grad_z),
    .is_final  (is_final),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  // back: store update, microprogrammed flux and row output
  vf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .done        (done),
    .component   (component),
    .flux_x      (flux_x),
    .flux_y      (flux_y),
    .flux_z      (flux_z),
    .bad_density (bad_density),
    .saturated   (saturated),
    .row_last    (row_last)
  );

endmodule

// ===== dv/compressible_viscous_flux_top_tb.sv =====
`timescale 1ns / 100ps

module compressible_viscous_flux_top_tb
  import vf_pkg::*;
;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam int SettleCycles = 400;
  localparam int StallLimit = 20000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  var_index;
  logic [31:0] value;
  logic [31:0] grad_x;
  logic [31:0] grad_y;
  logic [31:0] grad_z;
  logic        is_final;
  logic        cfg_we;
  logic        cfg_index;
  logic [30:0] cfg_data;
  logic        done;
  logic [2:0]  component;
  logic [31:0] flux_x;
  logic [31:0] flux_y;
  logic [31:0] flux_z;
  logic        bad_density;
  logic        saturated;
  logic        row_last;

  compressible_viscous_flux_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .var_index(var_index), .value(value), .grad_x(grad_x), .grad_y(grad_y),
    .grad_z(grad_z), .is_final(is_final),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .component(component), .flux_x(flux_x), .flux_y(flux_y),
    .flux_z(flux_z), .bad_density(bad_density), .saturated(saturated),
    .row_last(row_last)
  );

  // one flux row as the block should present it
  typedef struct {
    logic [2:0]  comp;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic        bad;
    logic        sat;
    logic        last;
  } flux_row_t;

  typedef struct {
    logic [2:0]  idx;
    logic [31:0] val;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic        fin;
    logic        typed_bad;  // expected rows typed in: bad density
  } load_t;

  flux_row_t pending_rows[$];

  // mirror of the block state
  longint var_mirror[5];
  longint grad_mirror[5][3];
  longint ire_mirror;
  longint gop_mirror;
  bit     clamp_hit;

  int err_cnt;
  int item_cnt;
  int row_cnt;
  int final_cnt;
  int bad_cnt;
  int sat_cnt;
  int stall_cnt;
  bit idle_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- fixed point arithmetic ----------------

  // product rounded half away from zero, saturated
  function automatic longint q_mul(longint a, longint b);
    bit     neg;
    longint ua;
    longint ub;
    longint mag;
    longint lim;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    mag = (ua * ub + 64'sd32768) >>> 16;
    lim = QMax + (neg ? 1 : 0);
    if (mag > lim) begin
      clamp_hit = 1'b1;
      return neg ? QMin : QMax;
    end
    return neg ? -mag : mag;
  endfunction

  function automatic longint q_sat(longint s);
    if (s > QMax) begin
      clamp_hit = 1'b1;
      return QMax;
    end
    if (s < QMin) begin
      clamp_hit = 1'b1;
      return QMin;
    end
    return s;
  endfunction

  function automatic longint q_add(longint a, longint b);
    return q_sat(a + b);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return q_sat(a - b);
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // ---------------- flux predictor ----------------

  task automatic push_bad_rows();
    flux_row_t r;
    for (int k = 0; k < 5; k++) begin
      r.comp = 3'(k);
      r.fx = '0;
      r.fy = '0;
      r.fz = '0;
      r.bad = 1'b1;
      r.sat = 1'b0;
      r.last = (k == 4);
      pending_rows.push_back(r);
    end
  endtask

  task automatic predict_flux();
    longint    rho, recip, div, lamdiv, eps, kcond, g, s, t;
    longint    vel[3];
    longint    lg[3][3];
    longint    tau[3][3];
    longint    heat[3];
    longint    rowv[5][3];
    flux_row_t r;
    clamp_hit = 1'b0;
    rho = var_mirror[0];
    if (rho <= 0) begin
      push_bad_rows();
      return;
    end
    recip = (64'sd1 << 32) / rho;
    if (recip > QMax) begin
      clamp_hit = 1'b1;
      recip = QMax;
    end
    for (int a = 0; a < 3; a++) vel[a] = q_mul(var_mirror[a+1], recip);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        lg[a][b] = q_mul(q_sub(grad_mirror[a+1][b], q_mul(vel[a], grad_mirror[0][b])),
                         recip);
    div = q_add(q_add(lg[0][0], lg[1][1]), lg[2][2]);
    lamdiv = q_mul(longint'(TwoThirds), div);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        t = q_add(lg[a][b], lg[b][a]);
        if (a == b) t = q_sub(t, lamdiv);
        tau[a][b] = q_mul(t, ire_mirror);
      end
    eps = q_mul(var_mirror[4], recip);
    kcond = q_mul(ire_mirror, gop_mirror);
    for (int b = 0; b < 3; b++) begin
      g = q_mul(q_sub(grad_mirror[4][b], q_mul(eps, grad_mirror[0][b])), recip);
      for (int a = 0; a < 3; a++) g = q_sub(g, q_mul(lg[a][b], vel[a]));
      heat[b] = q_mul(g, kcond);
    end
    for (int b = 0; b < 3; b++) rowv[0][b] = 0;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) rowv[a+1][b] = tau[a][b];
    for (int a = 0; a < 3; a++) begin
      s = heat[a];
      for (int b = 0; b < 3; b++) s = q_add(s, q_mul(tau[a][b], vel[b]));
      rowv[4][a] = s;
    end
    for (int k = 0; k < 5; k++) begin
      r.comp = 3'(k);
      r.fx = rowv[k][0][31:0];
      r.fy = rowv[k][1][31:0];
      r.fz = rowv[k][2][31:0];
      r.bad = 1'b0;
      r.sat = clamp_hit;
      r.last = (k == 4);
      pending_rows.push_back(r);
    end
  endtask

  // update the mirror for one accepted item and queue its rows
  task automatic take_item(load_t it);
    item_cnt++;
    if (it.idx < NumVars) begin
      var_mirror[it.idx] = sx(it.val);
      grad_mirror[it.idx][0] = sx(it.gx);
      grad_mirror[it.idx][1] = sx(it.gy);
      grad_mirror[it.idx][2] = sx(it.gz);
    end
    if (it.fin) begin
      final_cnt++;
      if (it.typed_bad) push_bad_rows();
      else predict_flux();
    end
  endtask

  // ---------------- drivers ----------------

  // start stays high from one transfer to the next when there is no gap
  task automatic send_load(load_t it);
    int gap;
    gap = (idle_on && ($urandom_range(0, 3) == 0)) ? $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    var_index = it.idx;
    value     = it.val;
    grad_x    = it.gx;
    grad_y    = it.gy;
    grad_z    = it.gz;
    is_final  = it.fin;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    take_item(it);
  endtask

  // wait until the block has gone quiet, then write both registers
  task automatic write_regs(logic [30:0] ire, logic [30:0] gop);
    @(negedge clk);
    start = 1'b0;
    wait (pending_rows.size() == 0);
    repeat (SettleCycles) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = 1'b0;
    cfg_data  = ire;
    @(negedge clk);
    cfg_index = 1'b1;
    cfg_data  = gop;
    @(negedge clk);
    cfg_we = 1'b0;
    ire_mirror = longint'(ire);
    gop_mirror = longint'(gop);
  endtask

  // ---------------- random content ----------------

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      2: return 32'($signed($urandom_range(0, 512)) - 256);
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    endcase
  endfunction

  function automatic logic [31:0] pick_density();
    case ($urandom_range(0, 15))
      0: return 32'h0;
      1: return $urandom() | 32'h80000000;
      2: return $urandom_range(1, 32'h7fffffff);
      3: return $urandom_range(1, 64);
      default: return $urandom_range(1 << 12, 1 << 21);
    endcase
  endfunction

  function automatic load_t mk_load(int idx, bit fin);
    load_t it;
    it.idx = 3'(idx);
    it.val = (idx == 0) ? pick_density() : pick_word();
    it.gx  = pick_word();
    it.gy  = pick_word();
    it.gz  = pick_word();
    it.fin = fin;
    it.typed_bad = 1'b0;
    return it;
  endfunction

  // five loads in shuffled order, the last one final
  task automatic send_set();
    int ord[5];
    int j, tmp;
    for (int k = 0; k < 5; k++) ord[k] = k;
    for (int k = 4; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = ord[k];
      ord[k] = ord[j];
      ord[j] = tmp;
    end
    for (int k = 0; k < 5; k++) send_load(mk_load(ord[k], k == 4));
  endtask

  // stray loads: out-of-range indexes, early finals, partial rewrites
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 1)) send_load(mk_load($urandom_range(5, 7), $urandom_range(0, 1)));
      else send_load(mk_load($urandom_range(0, 4), $urandom_range(0, 3) == 0));
    end
  endtask

  task automatic random_phase(int n_items);
    int base;
    base = item_cnt;
    while (item_cnt - base < n_items) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_set();
    end
  endtask

  // ---------------- result checking ----------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    flux_row_t w;
    if (!rst && done) begin
      row_cnt++;
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected row", 32'(component), 32'h0);
      end else begin
        w = pending_rows.pop_front();
        if (w.bad) bad_cnt++;
        if (w.sat) sat_cnt++;
        if (component !== w.comp) report_mismatch("component", 32'(component), 32'(w.comp));
        if (flux_x !== w.fx) report_mismatch("flux_x", flux_x, w.fx);
        if (flux_y !== w.fy) report_mismatch("flux_y", flux_y, w.fy);
        if (flux_z !== w.fz) report_mismatch("flux_z", flux_z, w.fz);
        if (bad_density !== w.bad)
          report_mismatch("bad_density", 32'(bad_density), 32'(w.bad));
        if (saturated !== w.sat) report_mismatch("saturated", 32'(saturated), 32'(w.sat));
        if (row_last !== w.last) report_mismatch("row_last", 32'(row_last), 32'(w.last));
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("compressible_viscous_flux_top_tb: done, errors");
      $finish;
    end
  end

  // ---------------- directed table ----------------

  load_t directed[$];

  task automatic add_row(int idx, logic [31:0] v, logic [31:0] x, logic [31:0] y,
                         logic [31:0] z, bit fin, bit typed);
    load_t it;
    it.idx = 3'(idx);
    it.val = v;
    it.gx = x;
    it.gy = y;
    it.gz = z;
    it.fin = fin;
    it.typed_bad = typed;
    directed.push_back(it);
  endtask

  task automatic build_table();
    // unit density at rest-ish flow, every store written before the first final
    add_row(0, 32'h0001_0000, 32'h0000_1000, 32'hffff_f000, 32'h0000_0800, 0, 0);
    add_row(1, 32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 32'hffff_c000, 0, 0);
    add_row(2, 32'hffff_8000, 32'h0000_2000, 32'h0002_0000, 32'h0000_0100, 0, 0);
    add_row(3, 32'h0000_4000, 32'hffff_0000, 32'h0000_0000, 32'h0001_8000, 0, 0);
    add_row(4, 32'h0003_0000, 32'h0000_8000, 32'hffff_8000, 32'h0000_4000, 1, 0);
    // zero density, then most negative density
    add_row(0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 1);
    add_row(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1, 1);
    // smallest positive density: reciprocal clamps
    add_row(0, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0000, 1, 0);
    // extreme momenta and energy
    add_row(1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
    add_row(2, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    add_row(3, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 0, 0);
    add_row(4, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1, 0);
    // largest density
    add_row(0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 0);
    // out-of-range indexes store nothing, a final one still computes
    add_row(0, 32'h0002_0000, 32'h0000_4000, 32'h0000_2000, 32'hffff_e000, 0, 0);
    add_row(5, 32'hdead_beef, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 0, 0);
    add_row(6, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1, 0);
    add_row(7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 0);
    // moderate set again, final on momentum
    add_row(4, 32'h0001_8000, 32'h0000_0400, 32'h0000_0200, 32'h0000_0100, 0, 0);
    add_row(1, 32'h0000_2000, 32'h0000_0800, 32'hffff_fc00, 32'h0000_0400, 1, 0);
  endtask

  // ---------------- main sequence ----------------

  initial begin
    rst = 1'b1;
    start = 1'b0;
    var_index = '0;
    value = '0;
    grad_x = '0;
    grad_y = '0;
    grad_z = '0;
    is_final = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    err_cnt = 0;
    item_cnt = 0;
    row_cnt = 0;
    final_cnt = 0;
    bad_cnt = 0;
    sat_cnt = 0;
    stall_cnt = 0;
    idle_on = 1'b1;
    ire_mirror = 6554;
    gop_mirror = 127431;
    for (int k = 0; k < 5; k++) begin
      var_mirror[k] = 0;
      for (int b = 0; b < 3; b++) grad_mirror[k][b] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part on the reset register values
    build_table();
    foreach (directed[k]) send_load(directed[k]);

    // random phases across register settings, extremes included
    write_regs(31'd0, 31'h7fff_ffff);
    random_phase(70);
    write_regs(31'h7fff_ffff, 31'd0);
    random_phase(70);
    write_regs(31'h7fff_ffff, 31'h7fff_ffff);
    random_phase(60);
    write_regs(31'($urandom_range(1, 1 << 17)), 31'($urandom_range(1, 1 << 18)));
    random_phase(80);
    write_regs(31'($urandom()), 31'($urandom()));
    random_phase(60);
    // back to the reset values, and no idling at the end
    write_regs(31'd6554, 31'd127431);
    idle_on = 1'b0;
    random_phase(110);

    @(negedge clk);
    start = 1'b0;
    wait (pending_rows.size() == 0);
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d loads, %0d flux runs, %0d rows checked", item_cnt, final_cnt,
             row_cnt);
    $display("rows with bad density %0d, with clamping %0d, six register settings",
             bad_cnt, sat_cnt);
    if (err_cnt == 0 && pending_rows.size() == 0) begin
      $display("compressible_viscous_flux_top_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d rows still owed", err_cnt, pending_rows.size());
      $display("compressible_viscous_flux_top_tb: done, errors");
    end
    $finish;
  end

endmodule
